// ----- hdl/krh_pkg.sv -----
// krh_pkg: shared types, constants and helpers for the k-mer rolling hash unit
// no dependencies; imported by kmer_rolling_hash_unit

package krh_pkg;

  localparam int unsigned HASH_W    = 31;
  localparam int unsigned CODE_W    = 3;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned CFG_ADDR_W = 8;
  localparam int unsigned STEP_W    = 5;

  // last step of a 31-bit serial multiply
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(HASH_W - 1);

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_MODULUS = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BASE    = 8'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_INVERSE = 8'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_TOP     = 8'd3;

  // ascii characters
  localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
  localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;
  localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;
  localparam logic [CHAR_W-1:0] CHAR_N = 8'h4e;

  // base codes
  localparam logic [CODE_W-1:0] CODE_A = 3'd1;
  localparam logic [CODE_W-1:0] CODE_C = 3'd2;
  localparam logic [CODE_W-1:0] CODE_G = 3'd3;
  localparam logic [CODE_W-1:0] CODE_T = 3'd4;
  localparam logic [CODE_W-1:0] CODE_N = 3'd5;

  localparam logic [HASH_W-1:0] MOD_MIN     = 31'd2;
  localparam logic [HASH_W-1:0] MODULUS_RST = 31'h7fffffff;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_F_TERM,
    ST_F_HASH,
    ST_F_ADD,
    ST_F_QRED,
    ST_F_POW,
    ST_R_HASH,
    ST_R_SUB,
    ST_R_SHIFT,
    ST_R_ADDED,
    ST_R_ADD,
    ST_DONE
  } krh_state_t;

  function automatic logic [CODE_W-1:0] char_code(input logic [CHAR_W-1:0] ch);
    logic [CODE_W-1:0] c;
    unique case (ch)
      CHAR_A:  c = CODE_A;
      CHAR_C:  c = CODE_C;
      CHAR_G:  c = CODE_G;
      CHAR_T:  c = CODE_T;
      default: c = CODE_N;
    endcase
    return c;
  endfunction

  function automatic logic char_bad(input logic [CHAR_W-1:0] ch);
    logic b;
    unique case (ch)
      CHAR_A, CHAR_C, CHAR_G, CHAR_T, CHAR_N: b = 1'b0;
      default:                                b = 1'b1;
    endcase
    return b;
  endfunction

  // code mod m for m >= 2; a code is at most 5, so below 3m
  function automatic logic [CODE_W-1:0] small_mod(input logic [CODE_W-1:0] c,
                                                  input logic [HASH_W-1:0] m);
    logic [HASH_W:0] cx;
    logic [HASH_W:0] m1;
    logic [HASH_W:0] m2;
    logic [HASH_W:0] r;
    cx = {{(HASH_W-CODE_W+1){1'b0}}, c};
    m1 = {1'b0, m};
    m2 = {m, 1'b0};
    if (cx >= m2) begin
      r = cx - m2;
    end else if (cx >= m1) begin
      r = cx - m1;
    end else begin
      r = cx;
    end
    return r[CODE_W-1:0];
  endfunction

endpackage

// ----- hdl/kmer_rolling_hash_unit.sv -----
// kmer_rolling_hash_unit: polynomial rolling hash over the last k bases of a stream
// depends on krh_pkg; one serial modular multiply-add unit under a small sequencer
//
//   channel | dir | handshake           | payload
//   --------+-----+---------------------+---------------------------------------------
//   in      | in  | in_tvalid/in_tready | tdata: base_char  tuser: restart
//   out     | out | out_tvalid/out_tready | tdata: hash_value  tuser: window_full, bad_base
//   cfg     | in  | cfg_valid/cfg_ready | cfg_addr: register index  cfg_data: value
//
// a base is taken only while the sequencer is idle, so the unit does not take a new base
// until the last one's result has gone to the output register; each modular product
// walks the 31 multiplier bits through the one shared double-add-reduce unit,
// one bit a cycle.
// reset is synchronous and active low; it clears the window, fill count, hash,
// running power and the configuration registers to their defaults.
// in_tready is high only while the sequencer is idle; a result waiting in the output
// register does not block the next base, only the hand-over of that base's result.
// cfg_ready is always high.

module kmer_rolling_hash_unit
  import krh_pkg::*;
#(
  parameter int unsigned KMER_LENGTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [CHAR_W-1:0]     in_tdata,   // [7:0] base_char
  input  logic [0:0]            in_tuser,   // [0] restart

  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [HASH_W:0]       out_tdata,  // [30:0] hash_value, [31] zero fill
  output logic [1:0]            out_tuser,  // [0] window_full, [1] bad_base

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [HASH_W-1:0]     cfg_data
);

  localparam int unsigned FILL_W = $clog2(KMER_LENGTH + 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(KMER_LENGTH);

  // configuration registers
  logic [HASH_W-1:0] modulus_r, base_r, inverse_r, top_r;

  // window and running state
  logic [CODE_W-1:0] window_r [KMER_LENGTH];
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [HASH_W-1:0] hash_r, hash_nxt;
  logic [HASH_W-1:0] power_r, power_nxt;

  // sequencer and shared unit registers
  krh_state_t        state_r, state_nxt;
  logic [HASH_W-1:0] acc_r, acc_nxt;
  logic [HASH_W-1:0] mcand_r, mcand_nxt;
  logic [HASH_W-1:0] mplier_r, mplier_nxt;
  logic [HASH_W-1:0] tmp_r, tmp_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [CODE_W-1:0] cred_r, cred_nxt;
  logic              full_r, full_nxt;
  logic              bad_r, bad_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [HASH_W-1:0] out_hash_r, out_hash_nxt;
  logic              out_full_r, out_full_nxt;
  logic              out_bad_r, out_bad_nxt;

  logic              in_acc;
  logic              restart;
  logic [CODE_W-1:0] in_code;
  logic [CODE_W-1:0] old_red;
  logic [HASH_W-1:0] mod_used;
  logic              roll_path;
  logic [FILL_W-1:0] fill_after;
  logic              last_step;

  // shared unit: acc*2 + bit*mcand (or acc + tmp), reduced from below 3m
  logic              op_add;
  logic [HASH_W+1:0] unit_sum;
  logic [HASH_W+1:0] unit_red;
  logic [HASH_W-1:0] unit_res;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid & in_tready;
  assign restart    = in_tuser[0];
  assign in_code    = char_code(in_tdata);
  assign mod_used   = (modulus_r < MOD_MIN) ? MOD_MIN : modulus_r;
  assign old_red    = small_mod(window_r[0], mod_used);
  assign roll_path  = !restart && (fill_r == FILL_FULL);
  assign fill_after = restart ? FILL_W'(1) :
                      ((fill_r == FILL_FULL) ? fill_r : fill_r + FILL_W'(1));
  assign last_step  = (step_r == '0);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_hash_r};
  assign out_tuser  = {out_bad_r, out_full_r};

  assign op_add = (state_r == ST_F_ADD) || (state_r == ST_R_SUB) || (state_r == ST_R_ADD);

  always_comb begin
    if (op_add) begin
      unit_sum = {2'b00, acc_r} + {2'b00, tmp_r};
    end else begin
      unit_sum = {1'b0, acc_r, 1'b0} +
                 {2'b00, (mplier_r[HASH_W-1] ? mcand_r : '0)};
    end
    if (unit_sum >= {1'b0, mod_used, 1'b0}) begin
      unit_red = unit_sum - {1'b0, mod_used, 1'b0};
    end else if (unit_sum >= {2'b00, mod_used}) begin
      unit_red = unit_sum - {2'b00, mod_used};
    end else begin
      unit_red = unit_sum;
    end
  end

  assign unit_res = unit_red[HASH_W-1:0];

  // configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MODULUS_RST;
      base_r    <= HASH_W'(1);
      inverse_r <= HASH_W'(1);
      top_r     <= HASH_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        REG_MODULUS: modulus_r <= cfg_data;
        REG_BASE:    base_r    <= cfg_data;
        REG_INVERSE: inverse_r <= cfg_data;
        REG_TOP:     top_r     <= cfg_data;
        default:     ;
      endcase
    end
  end

  // window shift line: newest code enters at the top, oldest sits at index 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KMER_LENGTH; i++) begin
        window_r[i] <= '0;
      end
    end else if (in_acc) begin
      for (int i = 0; i < KMER_LENGTH - 1; i++) begin
        window_r[i] <= restart ? '0 : window_r[i+1];
      end
      window_r[KMER_LENGTH-1] <= in_code;
    end
  end

  // state register and control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      hash_r      <= '0;
      power_r     <= HASH_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      hash_r      <= hash_nxt;
      power_r     <= power_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    mcand_r    <= mcand_nxt;
    mplier_r   <= mplier_nxt;
    tmp_r      <= tmp_nxt;
    step_r     <= step_nxt;
    cred_r     <= cred_nxt;
    full_r     <= full_nxt;
    bad_r      <= bad_nxt;
    out_hash_r <= out_hash_nxt;
    out_full_r <= out_full_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    hash_nxt      = hash_r;
    power_nxt     = power_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    tmp_nxt       = tmp_r;
    step_nxt      = step_r;
    cred_nxt      = cred_r;
    full_nxt      = full_r;
    bad_nxt       = bad_r;
    out_hash_nxt  = out_hash_r;
    out_full_nxt  = out_full_r;
    out_bad_nxt   = out_bad_r;
    out_valid_nxt = out_valid_r && !out_tready;

    // serial multiply: shift the multiplier out msb first
    if (!op_add && state_r != ST_IDLE && state_r != ST_DONE) begin
      acc_nxt    = unit_res;
      mplier_nxt = {mplier_r[HASH_W-2:0], 1'b0};
      step_nxt   = step_r - STEP_W'(1);
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cred_nxt = small_mod(in_code, mod_used);
          bad_nxt  = char_bad(in_tdata);
          fill_nxt = fill_after;
          full_nxt = (fill_after == FILL_FULL);
          acc_nxt  = '0;
          step_nxt = STEP_LAST;
          if (restart) begin
            hash_nxt  = '0;
            power_nxt = HASH_W'(1);
          end
          if (roll_path) begin
            // reduce hash first; tmp holds m minus the oldest code for the subtract
            mcand_nxt  = HASH_W'(1);
            mplier_nxt = hash_r;
            tmp_nxt    = (old_red == '0) ? '0 :
                         mod_used - {{(HASH_W-CODE_W){1'b0}}, old_red};
            state_nxt  = ST_R_HASH;
          end else begin
            // term = code * power
            mcand_nxt  = {{(HASH_W-CODE_W){1'b0}}, small_mod(in_code, mod_used)};
            mplier_nxt = restart ? HASH_W'(1) : power_r;
            state_nxt  = ST_F_TERM;
          end
        end
      end

      ST_F_TERM: begin
        if (last_step) begin
          tmp_nxt    = unit_res;
          acc_nxt    = '0;
          mcand_nxt  = HASH_W'(1);
          mplier_nxt = hash_r;
          step_nxt   = STEP_LAST;
          state_nxt  = ST_F_HASH;
        end
      end

      ST_F_HASH: begin
        if (last_step) begin
          state_nxt = ST_F_ADD;
        end
      end

      ST_F_ADD: begin
        hash_nxt   = unit_res;
        acc_nxt    = '0;
        mcand_nxt  = HASH_W'(1);
        mplier_nxt = base_r;
        step_nxt   = STEP_LAST;
        state_nxt  = ST_F_QRED;
      end

      ST_F_QRED: begin
        if (last_step) begin
          // q mod m becomes the multiplicand for the next power
          acc_nxt    = '0;
          mcand_nxt  = unit_res;
          mplier_nxt = power_r;
          step_nxt   = STEP_LAST;
          state_nxt  = ST_F_POW;
        end
      end

      ST_F_POW: begin
        if (last_step) begin
          power_nxt = unit_res;
          state_nxt = ST_DONE;
        end
      end

      ST_R_HASH: begin
        if (last_step) begin
          state_nxt = ST_R_SUB;
        end
      end

      ST_R_SUB: begin
        // difference times the inverse of q
        acc_nxt    = '0;
        mcand_nxt  = unit_res;
        mplier_nxt = inverse_r;
        step_nxt   = STEP_LAST;
        state_nxt  = ST_R_SHIFT;
      end

      ST_R_SHIFT: begin
        if (last_step) begin
          tmp_nxt    = unit_res;
          acc_nxt    = '0;
          mcand_nxt  = {{(HASH_W-CODE_W){1'b0}}, cred_r};
          mplier_nxt = top_r;
          step_nxt   = STEP_LAST;
          state_nxt  = ST_R_ADDED;
        end
      end

      ST_R_ADDED: begin
        if (last_step) begin
          state_nxt = ST_R_ADD;
        end
      end

      ST_R_ADD: begin
        hash_nxt  = unit_res;
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_hash_nxt  = full_r ? hash_r : '0;
          out_full_nxt  = full_r;
          out_bad_nxt   = bad_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- verif/kmer_rolling_hash_unit_test.sv -----
// kmer_rolling_hash_unit_test: self-checking bench for the k-mer rolling hash unit
// needs krh_pkg and kmer_rolling_hash_unit; predicts every hash from its own copy of the
// window and the hash registers, with random stalls on both streams
`timescale 1ns / 100ps

module kmer_rolling_hash_unit_test;
  import krh_pkg::*;

  localparam int unsigned KMER_LEN    = 32;
  localparam int unsigned STALL_LIMIT = 3000;  // cycles with no request moving at all
  localparam int unsigned HOLD_CYCLES = 700;   // long receiver hold-off, several bases deep
  localparam int unsigned TAIL_CYCLES = 150;   // a bit over the slowest base
  localparam logic [HASH_W-1:0] PRIME_M = 31'h7fffffff;

  // one expected result
  typedef struct packed {
    logic [HASH_W-1:0] hash_value;
    logic              window_full;
    logic              bad_base;
  } hash_result_t;

  // predicts the hash of the last k bases and holds the hashes still to come
  class kmer_hash_ledger;
    logic [HASH_W-1:0] modulus;
    logic [HASH_W-1:0] mult;
    logic [HASH_W-1:0] inverse;
    logic [HASH_W-1:0] top;
    logic [CODE_W-1:0] window [KMER_LEN];
    int unsigned       fill;
    logic [HASH_W-1:0] hash;
    logic [HASH_W-1:0] power;
    hash_result_t      expected_hashes[$];
    int unsigned       failures;

    function new();
      modulus  = MODULUS_RST;
      mult     = 31'd1;
      inverse  = 31'd1;
      top      = 31'd1;
      failures = 0;
      clear_window();
    endfunction

    function void clear_window();
      foreach (window[i]) window[i] = '0;
      fill  = 0;
      hash  = '0;
      power = 31'd1;
    endfunction

    function longint unsigned mul_mod(longint unsigned a, longint unsigned b,
                                      longint unsigned m);
      return ((a % m) * (b % m)) % m;
    endfunction

    function void write_register(logic [CFG_ADDR_W-1:0] addr, logic [HASH_W-1:0] data);
      case (addr)
        REG_MODULUS: modulus = data;
        REG_BASE:    mult    = data;
        REG_INVERSE: inverse = data;
        REG_TOP:     top     = data;
        default: ;  // unmapped index, dropped
      endcase
    endfunction

    // accepted base: roll the window and queue the hash it produces
    function void take_base(logic [CHAR_W-1:0] ch, logic restart);
      longint unsigned   m;
      longint unsigned   diff;
      logic [CODE_W-1:0] code;
      logic              bad;
      hash_result_t      r;
      int                i;
      m   = (modulus < MOD_MIN) ? MOD_MIN : modulus;
      bad = 1'b0;
      case (ch)
        CHAR_A:  code = CODE_A;
        CHAR_C:  code = CODE_C;
        CHAR_G:  code = CODE_G;
        CHAR_T:  code = CODE_T;
        CHAR_N:  code = CODE_N;
        default: begin
          code = CODE_N;  // unknown character counts as N
          bad  = 1'b1;
        end
      endcase
      if (restart) clear_window();
      if (fill < KMER_LEN) begin
        hash  = HASH_W'((hash % m + mul_mod(code, power, m)) % m);
        power = HASH_W'(mul_mod(power, mult, m));
        window[fill] = code;
        fill++;
      end else begin
        // drop the oldest code, add m first so the difference stays positive
        diff = (hash % m + m - window[0] % m) % m;
        hash = HASH_W'((mul_mod(diff, inverse, m) + mul_mod(code, top, m)) % m);
        for (i = 0; i < KMER_LEN - 1; i++) window[i] = window[i+1];
        window[KMER_LEN-1] = code;
      end
      r.window_full = (fill >= KMER_LEN);
      r.hash_value  = r.window_full ? hash : '0;
      r.bad_base    = bad;
      expected_hashes.push_back(r);
    endfunction

    function void flag(string field, longint unsigned want, longint unsigned got);
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
      failures++;
    endfunction

    // accepted result: compare with the oldest expected hash
    function void check_hash(logic [HASH_W:0] tdata, logic [1:0] tuser);
      hash_result_t want;
      if (expected_hashes.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual hash %h tuser %b",
                 $time, tdata, tuser);
        failures++;
        return;
      end
      want = expected_hashes.pop_front();
      if (tdata[HASH_W-1:0] !== want.hash_value) flag("hash_value", want.hash_value,
                                                      tdata[HASH_W-1:0]);
      if (tuser[0] !== want.window_full) flag("window_full", want.window_full, tuser[0]);
      if (tuser[1] !== want.bad_base) flag("bad_base", want.bad_base, tuser[1]);
    endfunction

    function int unsigned pending();
      return expected_hashes.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [CHAR_W-1:0]     in_tdata;   // [7:0] base_char
  logic [0:0]            in_tuser;   // [0] restart
  logic                  out_tvalid;
  logic                  out_tready;
  logic [HASH_W:0]       out_tdata;  // [30:0] hash_value, [31] zero fill
  logic [1:0]            out_tuser;  // [0] window_full, [1] bad_base
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [HASH_W-1:0]     cfg_data;

  kmer_hash_ledger ledger;
  int unsigned     bases_sent;
  int unsigned     hashes_seen;
  int unsigned     hold_left;
  bit              hold_done;
  int unsigned     idle_cycles;

  kmer_rolling_hash_unit #(
    .KMER_LENGTH(KMER_LEN)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // b^e mod m, used to build a self-consistent q, q^-1, q^(k-1) set
  function automatic logic [HASH_W-1:0] pow_mod(longint unsigned b, longint unsigned e,
                                                longint unsigned m);
    longint unsigned acc;
    longint unsigned sq;
    acc = 1;
    sq  = b % m;
    while (e != 0) begin
      if (e[0]) acc = (acc * sq) % m;
      sq = (sq * sq) % m;
      e  = e >> 1;
    end
    return acc[HASH_W-1:0];
  endfunction

  // mostly clean nucleotides, now and then any byte at all
  function automatic logic [CHAR_W-1:0] pick_char();
    logic [CHAR_W-1:0] clean [5];
    clean = '{CHAR_A, CHAR_C, CHAR_G, CHAR_T, CHAR_N};
    if ($urandom_range(99) < 7) return CHAR_W'($urandom_range(255));
    return clean[$urandom_range(4)];
  endfunction

  // one base request; valid stays up until the handshake
  task automatic send_base(input logic [CHAR_W-1:0] ch, input logic restart);
    bit steady;
    steady = (bases_sent >= 500 && bases_sent < 700);
    if (!steady) begin
      while ($urandom_range(99) < 23) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tuser  <= restart;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    ledger.take_base(ch, restart);
    bases_sent++;
  endtask

  // stop offering bases until every expected hash has come back
  task automatic wait_all_hashes();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  // caller lowers cfg_valid after the last write of a batch
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [HASH_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    ledger.write_register(addr, data);
  endtask

  // new hash setting, only with the unit idle; also pokes two unmapped indexes
  task automatic load_setting(input logic [HASH_W-1:0] m, input logic [HASH_W-1:0] q,
                              input logic [HASH_W-1:0] inv, input logic [HASH_W-1:0] tp);
    wait_all_hashes();
    write_reg(CFG_ADDR_W'($urandom_range(4, 255)), HASH_W'($urandom));
    write_reg(REG_MODULUS, m);
    write_reg(REG_BASE, q);
    write_reg(REG_INVERSE, inv);
    write_reg(REG_TOP, tp);
    write_reg(~REG_TOP, HASH_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // random sequences, long enough to fill and roll the window; optional drain midway
  task automatic random_run(input int count, input int pause_at);
    int i;
    for (i = 0; i < count; i++) begin
      if (i == pause_at) wait_all_hashes();
      send_base(pick_char(), ($urandom_range(69) == 0));
    end
  endtask

  // prime modulus with q, its inverse and q^(k-1) that agree with each other
  task automatic load_prime_setting();
    logic [HASH_W-1:0] q;
    q = HASH_W'($urandom_range(2, PRIME_M - 1));
    load_setting(PRIME_M, q, pow_mod(q, PRIME_M - 2, PRIME_M), pow_mod(q, KMER_LEN - 1, PRIME_M));
  endtask

  // result side: check accepted hashes, random ready with a steady stretch, one long hold-off
  initial begin
    out_tready  = 1'b0;
    hashes_seen = 0;
    hold_left   = 0;
    hold_done   = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        ledger.check_hash(out_tdata, out_tuser);
        hashes_seen++;
        if (hashes_seen == 900 && !hold_done) begin
          hold_left = HOLD_CYCLES;
          hold_done = 1'b1;
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (hashes_seen >= 500 && hashes_seen < 700) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 23);
      end
    end
  end

  // watchdog on cycles where no request moves anywhere
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t ns: no request moved for %0d cycles", $time, idle_cycles);
        $display("kmer_rolling_hash_unit regression: fail");
        $finish;
      end
    end
  end

  initial begin
    logic [CHAR_W:0] directed [25];
    directed = '{
      {1'b1, CHAR_A}, {1'b0, CHAR_C}, {1'b0, CHAR_G}, {1'b0, CHAR_T}, {1'b0, CHAR_N},
      {1'b0, 8'h00},  {1'b0, 8'hff},  {1'b0, 8'h61},  {1'b0, 8'h4d},  {1'b0, 8'h4f},
      {1'b0, 8'h40},  {1'b0, 8'h80},  {1'b0, 8'h7f},  {1'b0, CHAR_A}, {1'b1, CHAR_C},
      {1'b0, CHAR_G}, {1'b0, CHAR_T}, {1'b0, CHAR_N}, {1'b0, 8'h55},  {1'b1, CHAR_A},
      {1'b0, CHAR_C}, {1'b0, CHAR_G}, {1'b1, 8'haa},  {1'b0, CHAR_T}, {1'b0, CHAR_N}
    };
    ledger     = new();
    bases_sent = 0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    cfg_valid  = 1'b0;
    cfg_addr   = '0;
    cfg_data   = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults after reset: q = 1, so the hash is a plain sum of codes
    foreach (directed[i]) send_base(directed[i][CHAR_W-1:0], directed[i][CHAR_W]);
    random_run(200, -1);

    load_prime_setting();
    random_run(250, -1);

    // modulus below the minimum, base and inverse far above it, top at zero
    load_setting(31'd0, 31'h7fffffff, 31'h7fffffff, 31'd0);
    random_run(120, -1);

    // modulus smaller than the largest base code
    load_setting(31'd3, HASH_W'($urandom), HASH_W'($urandom), HASH_W'($urandom));
    random_run(150, -1);

    // largest modulus, registers at and just below it
    load_setting(PRIME_M, 31'h7ffffffe, 31'h7fffffff, 31'h7ffffffe);
    random_run(200, -1);

    // arbitrary modulus and registers, with a full drain partway
    load_setting(HASH_W'($urandom_range(2, PRIME_M)), HASH_W'($urandom), HASH_W'($urandom),
                 HASH_W'($urandom));
    random_run(250, 120);

    load_setting(31'd1, 31'd0, 31'd0, 31'd1);
    random_run(100, -1);

    load_prime_setting();
    random_run(150, -1);

    wait_all_hashes();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (ledger.pending() != 0) begin
      $display("%0t ns: %0d hashes never arrived", $time, ledger.pending());
      ledger.failures++;
    end
    if (ledger.failures == 0) begin
      $display("kmer_rolling_hash_unit regression: pass");
    end else begin
      $display("kmer_rolling_hash_unit regression: fail");
    end
    $finish;
  end

endmodule
